// ===== hw/rtl/pvp_pkg.sv =====
// Shared types and constants for the vertex-to-pixel projection core.
// No dependencies; used by pvp_div_step and project_vertex_to_pixel_core.
package pvp_pkg;

  localparam int NUM_COEF  = 12;
  localparam int COEF_W    = 48;
  localparam int VTX_W     = 32;
  localparam int DIM_W     = 14;
  localparam int PIX_W     = 16;
  localparam int DIV_W     = 100;  // remainder and shifted divisor width
  localparam int DIV_STEPS = 16;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd480;

  localparam logic [PIX_W-1:0] SAT_HIGH = 16'h7FFF;
  localparam logic [PIX_W-1:0] SAT_LOW  = 16'h8000;

  typedef struct packed {
    logic             w_zero;
    logic             clip_x;
    logic             clip_y;
    logic [PIX_W-1:0] sat_x;
    logic [PIX_W-1:0] sat_y;
  } side_t;

endpackage

// ===== hw/rtl/pvp_div_step.sv =====
// One restoring division step for both pixel axes, registered.
// Depends on pvp_pkg for widths and the side-band struct.
module pvp_div_step (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [pvp_pkg::DIV_W-1:0] in_mx,
  input  logic [pvp_pkg::DIV_W-1:0] in_my,
  input  logic [pvp_pkg::DIV_W-1:0] in_ds,
  input  logic [pvp_pkg::PIX_W-1:0] in_qx,
  input  logic [pvp_pkg::PIX_W-1:0] in_qy,
  input  pvp_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [pvp_pkg::DIV_W-1:0] out_mx,
  output logic [pvp_pkg::DIV_W-1:0] out_my,
  output logic [pvp_pkg::DIV_W-1:0] out_ds,
  output logic [pvp_pkg::PIX_W-1:0] out_qx,
  output logic [pvp_pkg::PIX_W-1:0] out_qy,
  output pvp_pkg::side_t            out_side
);

  logic ge_x;
  logic ge_y;

  assign ge_x = (in_mx >= in_ds);
  assign ge_y = (in_my >= in_ds);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // shift the divisor down one bit per step, quotient bits come out msb first
  always_ff @(posedge clk) begin
    if (en) begin
      out_mx   <= ge_x ? in_mx - in_ds : in_mx;
      out_my   <= ge_y ? in_my - in_ds : in_my;
      out_qx   <= {in_qx[pvp_pkg::PIX_W-2:0], ge_x};
      out_qy   <= {in_qy[pvp_pkg::PIX_W-2:0], ge_y};
      out_ds   <= in_ds >> 1;
      out_side <= in_side;
    end
  end

endmodule

// ===== hw/rtl/project_vertex_to_pixel_core.sv =====
// Vertex projection core: 3x4 transform, perspective divide, viewport map.
// Depends on pvp_pkg and pvp_div_step.
//
// Usage: the input channel (in_valid/in_ready) carries one word per item.
// kind = load writes coef_value into slot coef_index (slots 12..15 ignored)
// and yields no result. kind = vertex projects (vertex_x, vertex_y,
// vertex_z, 1) through the loaded matrix and yields one output word
// (pixel_x, pixel_y, clipped, w_zero) on out_valid/out_ready, in order.
// A load takes effect for every vertex accepted after it.
// Throughput: one item per cycle while the skid entry is empty; the
// pipeline is 8 arithmetic stages (partial products, full products, row
// sums, viewport offsets, viewport scaling, numerators, sign fix, range
// check) followed by 16 restoring divide stages, one quotient bit each.
// image_width / image_height are written through cfg_we/cfg_index/cfg_data;
// the user must do this only while the core is idle; the core does not enforce it.
// Reset: clears all valids, the matrix to zero, width 640 and height 480.
// Stall: an output register plus one skid entry hold results; when the skid
// entry is occupied the whole pipeline and in_ready hold until it drains.
module project_vertex_to_pixel_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [pvp_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [3:0]                        coef_index,
  input  logic signed [pvp_pkg::COEF_W-1:0] coef_value,
  input  logic signed [pvp_pkg::VTX_W-1:0]  vertex_x,
  input  logic signed [pvp_pkg::VTX_W-1:0]  vertex_y,
  input  logic signed [pvp_pkg::VTX_W-1:0]  vertex_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pvp_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [pvp_pkg::PIX_W-1:0]  pixel_y,
  output logic                              clipped,
  output logic                              w_zero
);

  localparam int DW = pvp_pkg::DIV_W;
  localparam int NS = pvp_pkg::DIV_STEPS;

  logic                             en;
  logic                             accept;
  logic [pvp_pkg::DIM_W-1:0]        image_width;
  logic [pvp_pkg::DIM_W-1:0]        image_height;
  logic signed [pvp_pkg::COEF_W-1:0] coef [pvp_pkg::NUM_COEF];
  logic signed [pvp_pkg::VTX_W-1:0] vtx [3];
  logic [8:1]                       vld;

  // stage 1: split 48x32 products
  logic signed [56:0]               prod_lo [9];
  logic signed [55:0]               prod_hi [9];
  logic signed [pvp_pkg::COEF_W-1:0] c3_s1 [3];
  // stage 2: full products
  logic signed [79:0]               prod_s2 [9];
  logic signed [pvp_pkg::COEF_W-1:0] c3_s2 [3];
  // stage 3: row sums
  logic signed [81:0]               xs_s3, ys_s3, ws_s3;
  // stage 4: viewport offsets folded in
  logic signed [82:0]               ax_s4, ay_s4;
  logic signed [81:0]               ws_s4;
  logic                             wz_s4;
  // stage 5: scaled partial products
  logic [41:0]                      px0_s5, px1_s5, py0_s5, py1_s5;
  logic signed [41:0]               px2_s5, py2_s5;
  logic signed [81:0]               ws_s5;
  logic                             wz_s5;
  // stage 6: numerators
  logic signed [97:0]               nx_s6, ny_s6;
  logic signed [81:0]               ws_s6;
  logic                             wz_s6;
  // stage 7: positive divisor
  logic signed [DW-1:0]             nx_s7, ny_s7;
  logic [DW-1:0]                    dd_s7;
  logic                             wz_s7;
  logic signed [DW-1:0]             nx_ext, ny_ext, d_ext;
  // stage 8: range check, divider entry
  logic [DW-1:0]                    lim;
  logic                             hi_x, lo_x, hi_y, lo_y;

  logic                             dv   [NS+1];
  logic [DW-1:0]                    dmx  [NS+1];
  logic [DW-1:0]                    dmy  [NS+1];
  logic [DW-1:0]                    dds  [NS+1];
  logic [pvp_pkg::PIX_W-1:0]        dqx  [NS+1];
  logic [pvp_pkg::PIX_W-1:0]        dqy  [NS+1];
  pvp_pkg::side_t                   dside[NS+1];

  // output register and skid entry
  logic                             skid_full;
  logic signed [pvp_pkg::PIX_W-1:0] res_px, res_py, skid_px, skid_py;
  logic                             res_clip, res_wz, skid_clip, skid_wz;
  logic                             incoming;
  logic                             take;

  assign en       = !skid_full;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;
  assign vtx[0]   = vertex_x;
  assign vtx[1]   = vertex_y;
  assign vtx[2]   = vertex_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pvp_pkg::WIDTH_RESET;
      image_height <= pvp_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pvp_pkg::REG_WIDTH:  image_width  <= cfg_data;
        pvp_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pvp_pkg::NUM_COEF; i++) coef[i] <= '0;
    end else if (accept && kind == pvp_pkg::KIND_LOAD &&
                 coef_index < 4'(pvp_pkg::NUM_COEF)) begin
      coef[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:1], accept && kind == pvp_pkg::KIND_VERTEX};
    end
  end

  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 3; gc++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod_lo[gr*3+gc] <= $signed({1'b0, coef[gr*4+gc][23:0]}) * vtx[gc];
          prod_hi[gr*3+gc] <= $signed(coef[gr*4+gc][47:24]) * vtx[gc];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c3_s1[gr] <= coef[gr*4+3];
        c3_s2[gr] <= c3_s1[gr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        prod_s2[k] <= $signed({prod_hi[k], 24'd0}) + 80'(prod_lo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_s3 <= 82'(prod_s2[0]) + 82'(prod_s2[1]) + 82'(prod_s2[2]) +
               $signed({{18{c3_s2[0][47]}}, c3_s2[0], 16'd0});
      ys_s3 <= 82'(prod_s2[3]) + 82'(prod_s2[4]) + 82'(prod_s2[5]) +
               $signed({{18{c3_s2[1][47]}}, c3_s2[1], 16'd0});
      ws_s3 <= 82'(prod_s2[6]) + 82'(prod_s2[7]) + 82'(prod_s2[8]) +
               $signed({{18{c3_s2[2][47]}}, c3_s2[2], 16'd0});
    end
  end

  // X*W + Wh*(W+1) = W*(X+Wh) + Wh, likewise for -Y with H
  always_ff @(posedge clk) begin
    if (en) begin
      ax_s4 <= 83'(xs_s3) + 83'(ws_s3);
      ay_s4 <= 83'(ws_s3) - 83'(ys_s3);
      ws_s4 <= ws_s3;
      wz_s4 <= (ws_s3 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0_s5 <= ax_s4[27:0] * image_width;
      px1_s5 <= ax_s4[55:28] * image_width;
      px2_s5 <= $signed(ax_s4[82:56]) * $signed({1'b0, image_width});
      py0_s5 <= ay_s4[27:0] * image_height;
      py1_s5 <= ay_s4[55:28] * image_height;
      py2_s5 <= $signed(ay_s4[82:56]) * $signed({1'b0, image_height});
      ws_s5  <= ws_s4;
      wz_s5  <= wz_s4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_s6 <= $signed({px2_s5, 56'd0}) + $signed({28'd0, px1_s5, 28'd0}) +
               $signed({56'd0, px0_s5}) + 98'(ws_s5);
      ny_s6 <= $signed({py2_s5, 56'd0}) + $signed({28'd0, py1_s5, 28'd0}) +
               $signed({56'd0, py0_s5}) + 98'(ws_s5);
      ws_s6 <= ws_s5;
      wz_s6 <= wz_s5;
    end
  end

  // flip signs so the divisor 2*Wh is positive
  assign nx_ext = DW'(nx_s6);
  assign ny_ext = DW'(ny_s6);
  assign d_ext  = $signed({{(DW-83){ws_s6[81]}}, ws_s6, 1'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      nx_s7 <= ws_s6[81] ? -nx_ext : nx_ext;
      ny_s7 <= ws_s6[81] ? -ny_ext : ny_ext;
      dd_s7 <= ws_s6[81] ? DW'(-d_ext) : DW'(d_ext);
      wz_s7 <= wz_s6;
    end
  end

  assign lim  = {dd_s7[DW-16:0], 15'd0};
  assign hi_x = nx_s7 >= $signed(lim);
  assign lo_x = nx_s7 < -$signed(lim);
  assign hi_y = ny_s7 >= $signed(lim);
  assign lo_y = ny_s7 < -$signed(lim);

  always_ff @(posedge clk) begin
    if (en) begin
      dmx[0]          <= DW'(nx_s7 + $signed(lim));
      dmy[0]          <= DW'(ny_s7 + $signed(lim));
      dds[0]          <= lim;
      dqx[0]          <= '0;
      dqy[0]          <= '0;
      dside[0].w_zero <= wz_s7;
      dside[0].clip_x <= hi_x || lo_x;
      dside[0].clip_y <= hi_y || lo_y;
      dside[0].sat_x  <= hi_x ? pvp_pkg::SAT_HIGH : pvp_pkg::SAT_LOW;
      dside[0].sat_y  <= hi_y ? pvp_pkg::SAT_HIGH : pvp_pkg::SAT_LOW;
    end
  end
  assign dv[0] = vld[8];

  for (genvar gs = 0; gs < NS; gs++) begin : g_div
    pvp_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[gs]),
      .in_mx    (dmx[gs]),
      .in_my    (dmy[gs]),
      .in_ds    (dds[gs]),
      .in_qx    (dqx[gs]),
      .in_qy    (dqy[gs]),
      .in_side  (dside[gs]),
      .out_valid(dv[gs+1]),
      .out_mx   (dmx[gs+1]),
      .out_my   (dmy[gs+1]),
      .out_ds   (dds[gs+1]),
      .out_qx   (dqx[gs+1]),
      .out_qy   (dqy[gs+1]),
      .out_side (dside[gs+1])
    );
  end

  // map quotient to signed pixel, apply saturation and zero-w override
  always_comb begin
    if (dside[NS].w_zero) begin
      res_px   = '0;
      res_py   = '0;
      res_clip = 1'b0;
      res_wz   = 1'b1;
    end else begin
      res_px   = dside[NS].clip_x ? dside[NS].sat_x : (dqx[NS] ^ pvp_pkg::SAT_LOW);
      res_py   = dside[NS].clip_y ? dside[NS].sat_y : (dqy[NS] ^ pvp_pkg::SAT_LOW);
      res_clip = dside[NS].clip_x || dside[NS].clip_y;
      res_wz   = 1'b0;
    end
  end

  assign incoming = en && dv[NS];
  assign take     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid <= skid_full || incoming;
      skid_full <= 1'b0;
    end else if (incoming) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_full) begin
        pixel_x <= skid_px;
        pixel_y <= skid_py;
        clipped <= skid_clip;
        w_zero  <= skid_wz;
      end else begin
        pixel_x <= res_px;
        pixel_y <= res_py;
        clipped <= res_clip;
        w_zero  <= res_wz;
      end
    end else if (incoming) begin
      skid_px   <= res_px;
      skid_py   <= res_py;
      skid_clip <= res_clip;
      skid_wz   <= res_wz;
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid) else $error("skid entry held without output word");

  a_wzero_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> pixel_x == '0 && pixel_y == '0 && !clipped)
    else $error("zero-w word carries pixel data");

  a_clip_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      pixel_x == pvp_pkg::SAT_HIGH || pixel_x == pvp_pkg::SAT_LOW ||
      pixel_y == pvp_pkg::SAT_HIGH || pixel_y == pvp_pkg::SAT_LOW)
    else $error("clipped word without saturated coordinate");

  a_vertex_enters: assert property (@(posedge clk) disable iff (rst)
    accept && kind == pvp_pkg::KIND_VERTEX |=> vld[1])
    else $error("accepted vertex missing from pipeline");
`endif

endmodule
